>>> hdl/tsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the typed slot pool
// Request codes, beat layouts and the control bundles between the sequencer
// and its storage blocks.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Default sizes
  localparam int LARGE_SLOTS_DEF = 16;
  localparam int SMALL_SLOTS_DEF = 2;
  localparam int LIST_SLOTS_DEF  = 32;

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 5;
  // Scan counter: one more bit than a list position so it can hold the list size
  localparam int CNT_W  = POS_W + 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WALK  = 2'd2;

  // Input beat
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic              pool_kind;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic              ok;
    logic              out_kind;
    logic [SLOT_W-1:0] out_slot;
    logic              listed;
    logic [POS_W-1:0]  list_position;
    logic              last;
  } out_item_t;

  // In-use bit update
  typedef struct packed {
    logic              set;
    logic              clr;
    logic              kind;
    logic [SLOT_W-1:0] idx;
  } pool_ctrl_t;

  // Active list update
  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [POS_W-1:0]  idx;
    logic              kind;
    logic [SLOT_W-1:0] slot;
  } list_ctrl_t;

  // One active list entry as read
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [SLOT_W-1:0] slot;
  } list_entry_t;

endpackage
`default_nettype wire

>>> hdl/tsp_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pool: in-use bits of the large and small slot pools
// One read port at a sequencer-chosen slot, one set/clear write port.
// Slots beyond a pool's size read as busy and ignore writes.
// ----------------------------------------------------------------------------
module tsp_pool #(
  parameter int LARGE_SLOTS = tsp_pkg::LARGE_SLOTS_DEF,
  parameter int SMALL_SLOTS = tsp_pkg::SMALL_SLOTS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         rd_kind,
  input  wire  [tsp_pkg::SLOT_W-1:0]  rd_idx,
  output logic                        rd_busy,
  input  tsp_pkg::pool_ctrl_t         ctrl
);

  localparam int LW = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;
  localparam int SW = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
  localparam logic [tsp_pkg::SLOT_W:0] LARGE_END = (tsp_pkg::SLOT_W+1)'(LARGE_SLOTS);
  localparam logic [tsp_pkg::SLOT_W:0] SMALL_END = (tsp_pkg::SLOT_W+1)'(SMALL_SLOTS);

  logic [LARGE_SLOTS-1:0] large_r;
  logic [SMALL_SLOTS-1:0] small_r;

  logic rd_in_large, rd_in_small, wr_in_large, wr_in_small;

  // range checks
  assign rd_in_large = ({1'b0, rd_idx} < LARGE_END);
  assign rd_in_small = ({1'b0, rd_idx} < SMALL_END);
  assign wr_in_large = ({1'b0, ctrl.idx} < LARGE_END);
  assign wr_in_small = ({1'b0, ctrl.idx} < SMALL_END);

  // read port
  always_comb begin
    if (rd_kind) begin
      rd_busy = rd_in_small ? small_r[rd_idx[SW-1:0]] : 1'b1;
    end else begin
      rd_busy = rd_in_large ? large_r[rd_idx[LW-1:0]] : 1'b1;
    end
  end

  // bit update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_r <= '0;
      small_r <= '0;
    end else if (ctrl.set || ctrl.clr) begin
      if (!ctrl.kind && wr_in_large) begin
        large_r[ctrl.idx[LW-1:0]] <= ctrl.set;
      end
      if (ctrl.kind && wr_in_small) begin
        small_r[ctrl.idx[SW-1:0]] <= ctrl.set;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/tsp_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_list: active list of handles
// Valid bits in resettable flops; handle fields are plain storage.
// One read port at the scan position, one write/clear port.
// ----------------------------------------------------------------------------
module tsp_list #(
  parameter int LIST_SLOTS = tsp_pkg::LIST_SLOTS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  [tsp_pkg::POS_W-1:0]  rd_idx,
  output tsp_pkg::list_entry_t       rd_entry,
  input  tsp_pkg::list_ctrl_t        ctrl
);

  localparam int PW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

  logic [LIST_SLOTS-1:0]     valid_r;
  logic                      kind_r [LIST_SLOTS];
  logic [tsp_pkg::SLOT_W-1:0] slot_r [LIST_SLOTS];

  // read port; the sequencer uses only entries read at positions inside the list
  assign rd_entry.valid = valid_r[rd_idx[PW-1:0]];
  assign rd_entry.kind  = kind_r[rd_idx[PW-1:0]];
  assign rd_entry.slot  = slot_r[rd_idx[PW-1:0]];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.wr) begin
      valid_r[ctrl.idx[PW-1:0]] <= 1'b1;
    end else if (ctrl.clr) begin
      valid_r[ctrl.idx[PW-1:0]] <= 1'b0;
    end
  end

  // handle fields, only meaningful while valid
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      kind_r[ctrl.idx[PW-1:0]] <= ctrl.kind;
      slot_r[ctrl.idx[PW-1:0]] <= ctrl.slot;
    end
  end

endmodule
`default_nettype wire

>>> hdl/typed_slot_pool_with_active_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// typed_slot_pool_with_active_list: slot allocator with a shared active list
// Two in-use bitmaps (large and small kind) and a handle list, driven by a
// scan sequencer stepping a slot or list position per cycle if no beat waits.
// ----------------------------------------------------------------------------
// Usage: one request at a time; in_stall is high from the beat after a request
// is taken until its final result beat is taken. Each scan step goes through
// the single compare path of the sequencer. An allocate scans the chosen pool
// for its lowest free slot, then the list for its lowest empty position. A
// free scans the list for the matching handle. A walk scans all LIST_SLOTS
// positions plus one end step, and out_stall can hold any result beat.
// Request code 3 is taken and dropped with no result.
// ----------------------------------------------------------------------------
module typed_slot_pool_with_active_list #(
  parameter int LARGE_SLOTS = tsp_pkg::LARGE_SLOTS_DEF,
  parameter int SMALL_SLOTS = tsp_pkg::SMALL_SLOTS_DEF,
  parameter int LIST_SLOTS  = tsp_pkg::LIST_SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  tsp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tsp_pkg::out_item_t  out_data
);

  localparam logic [tsp_pkg::CNT_W-1:0] LIST_END  = tsp_pkg::CNT_W'(LIST_SLOTS);
  localparam logic [tsp_pkg::CNT_W-1:0] LARGE_END = tsp_pkg::CNT_W'(LARGE_SLOTS);
  localparam logic [tsp_pkg::CNT_W-1:0] SMALL_END = tsp_pkg::CNT_W'(SMALL_SLOTS);
  localparam logic [tsp_pkg::CNT_W-1:0] CNT_ONE   = tsp_pkg::CNT_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_POOL, S_LIST, S_OUT} state_t;

  // walk entry held back until we know whether it is the last one
  typedef struct packed {
    logic                       valid;
    logic                       kind;
    logic [tsp_pkg::SLOT_W-1:0] slot;
    logic [tsp_pkg::POS_W-1:0]  pos;
  } pend_t;

  state_t                       state_r, state_nxt;
  logic [tsp_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [tsp_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic                         kind_r, kind_nxt;
  logic [tsp_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  pend_t                        pend_r, pend_nxt;
  tsp_pkg::out_item_t           out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  tsp_pkg::pool_ctrl_t          pool_ctrl;
  tsp_pkg::list_ctrl_t          list_ctrl;
  tsp_pkg::list_entry_t         entry;
  logic                         pool_busy;
  logic [tsp_pkg::CNT_W-1:0]    pool_end;
  logic                         list_at_end;
  logic                         handle_hit;
  logic [tsp_pkg::POS_W-1:0]    scan_pos;

  // storage
  tsp_pool #(
    .LARGE_SLOTS (LARGE_SLOTS),
    .SMALL_SLOTS (SMALL_SLOTS)
  ) u_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_kind (kind_r),
    .rd_idx  (idx_r[tsp_pkg::SLOT_W-1:0]),
    .rd_busy (pool_busy),
    .ctrl    (pool_ctrl)
  );

  tsp_list #(
    .LIST_SLOTS (LIST_SLOTS)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (scan_pos),
    .rd_entry (entry),
    .ctrl     (list_ctrl)
  );

  // shared compare path
  assign scan_pos    = idx_r[tsp_pkg::POS_W-1:0];
  assign pool_end    = kind_r ? SMALL_END : LARGE_END;
  assign list_at_end = (idx_r == LIST_END);
  assign handle_hit  = entry.valid && (entry.kind == kind_r) && (entry.slot == slot_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pool_ctrl     = '0;
    list_ctrl     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data.req_type;
          kind_nxt = in_data.pool_kind;
          slot_nxt = in_data.slot_index;
          idx_nxt  = '0;
          pend_nxt = '0;
          case (in_data.req_type)
            tsp_pkg::REQ_ALLOC: state_nxt = S_POOL;
            tsp_pkg::REQ_FREE: begin
              // in-use bit drops regardless of the list search
              pool_ctrl.clr  = 1'b1;
              pool_ctrl.kind = in_data.pool_kind;
              pool_ctrl.idx  = in_data.slot_index;
              state_nxt      = S_LIST;
            end
            tsp_pkg::REQ_WALK: state_nxt = S_LIST;
            default: ;
          endcase
        end
      end

      // lowest free slot of the chosen kind
      S_POOL: begin
        if (idx_r == pool_end) begin
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (!pool_busy) begin
          pool_ctrl.set  = 1'b1;
          pool_ctrl.kind = kind_r;
          pool_ctrl.idx  = idx_r[tsp_pkg::SLOT_W-1:0];
          slot_nxt       = idx_r[tsp_pkg::SLOT_W-1:0];
          idx_nxt        = '0;
          state_nxt      = S_LIST;
        end else begin
          idx_nxt = idx_r + CNT_ONE;
        end
      end

      // list scan: empty position, matching handle or next listed entry
      S_LIST: begin
        case (req_r)
          tsp_pkg::REQ_ALLOC: begin
            if (list_at_end) begin
              out_nxt          = '0;
              out_nxt.ok       = 1'b1;
              out_nxt.out_kind = kind_r;
              out_nxt.out_slot = slot_r;
              out_nxt.last     = 1'b1;
              out_valid_nxt    = 1'b1;
              state_nxt        = S_OUT;
            end else if (!entry.valid) begin
              list_ctrl.wr          = 1'b1;
              list_ctrl.idx         = scan_pos;
              list_ctrl.kind        = kind_r;
              list_ctrl.slot        = slot_r;
              out_nxt.ok            = 1'b1;
              out_nxt.out_kind      = kind_r;
              out_nxt.out_slot      = slot_r;
              out_nxt.listed        = 1'b1;
              out_nxt.list_position = scan_pos;
              out_nxt.last          = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_OUT;
            end else begin
              idx_nxt = idx_r + CNT_ONE;
            end
          end
          tsp_pkg::REQ_FREE: begin
            if (list_at_end) begin
              out_nxt          = '0;
              out_nxt.out_kind = kind_r;
              out_nxt.out_slot = slot_r;
              out_nxt.last     = 1'b1;
              out_valid_nxt    = 1'b1;
              state_nxt        = S_OUT;
            end else if (handle_hit) begin
              list_ctrl.clr         = 1'b1;
              list_ctrl.idx         = scan_pos;
              out_nxt.ok            = 1'b1;
              out_nxt.out_kind      = kind_r;
              out_nxt.out_slot      = slot_r;
              out_nxt.listed        = 1'b0;
              out_nxt.list_position = scan_pos;
              out_nxt.last          = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_OUT;
            end else begin
              idx_nxt = idx_r + CNT_ONE;
            end
          end
          default: begin
            // walk: emit the held entry when the next one shows up or the scan ends
            if (list_at_end) begin
              out_nxt      = '0;
              out_nxt.last = 1'b1;
              if (pend_r.valid) begin
                out_nxt.ok            = 1'b1;
                out_nxt.out_kind      = pend_r.kind;
                out_nxt.out_slot      = pend_r.slot;
                out_nxt.listed        = 1'b1;
                out_nxt.list_position = pend_r.pos;
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              idx_nxt = idx_r + CNT_ONE;
              if (entry.valid) begin
                pend_nxt.valid = 1'b1;
                pend_nxt.kind  = entry.kind;
                pend_nxt.slot  = entry.slot;
                pend_nxt.pos   = scan_pos;
                if (pend_r.valid) begin
                  out_nxt.ok            = 1'b1;
                  out_nxt.out_kind      = pend_r.kind;
                  out_nxt.out_slot      = pend_r.slot;
                  out_nxt.listed        = 1'b1;
                  out_nxt.list_position = pend_r.pos;
                  out_nxt.last          = 1'b0;
                  out_valid_nxt         = 1'b1;
                  state_nxt             = S_OUT;
                end
              end
            end
          end
        endcase
      end

      // hold the beat until taken; a walk resumes its scan
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_r.last ? S_IDLE : S_LIST;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      req_r       <= req_nxt;
      kind_r      <= kind_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      out_r       <= out_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_checker: port-level checks of the typed slot pool
// Watches both channels and flags sequencing slips of the request engine.
// ----------------------------------------------------------------------------
module tsp_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input tsp_pkg::in_item_t  in_data,
  input wire                out_valid,
  input wire                out_stall,
  input tsp_pkg::out_item_t out_data
);

  // a stalled request beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no request is taken while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result beat is pending");

  // after the final beat of a request no further beat follows at once
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("result beat right after the final beat");

  // a failed result carries no list information
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> !out_data.listed && (out_data.list_position == '0))
    else $error("failed result with list fields set");

endmodule

bind typed_slot_pool_with_active_list tsp_checker u_tsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
